@@ sv/q2m_pkg.sv @@
package q2m_pkg;
   localparam int DataWidth = 16;
   localparam int FracBits = DataWidth - 2;
   localparam int ProdWidth = 2 * DataWidth;
   localparam int NormWidth = ProdWidth + 2;
   localparam int NumWidth = ProdWidth + 3;
   localparam int QuoBits = FracBits + 2;
   localparam int NumCells = FracBits + 1;
   localparam int NumElems = 9;

   typedef logic signed [DataWidth-1:0] data_type;
   typedef logic [NormWidth-1:0] norm_type;

   typedef struct packed {
      logic valid;
      logic zero;
      norm_type n2;
      logic [NumElems-1:0] neg;
      logic [NumElems-1:0][NormWidth-1:0] rem;
      logic [NumElems-1:0][QuoBits-1:0] quo;
   } div_type;
endpackage

@@ sv/q2m_cell.sv @@
module q2m_cell (
   input  logic             clock,
   input  logic             reset,
   input  q2m_pkg::div_type cell_in,
   output q2m_pkg::div_type cell_out
);
   q2m_pkg::div_type stage_ff, stage_in;
   logic [q2m_pkg::NormWidth:0] shifted;

   always_comb begin
      stage_in = cell_in;
      shifted = '0;
      for (int k = 0; k < q2m_pkg::NumElems; k++) begin
         shifted = {cell_in.rem[k], 1'b0};
         if (shifted >= {1'b0, cell_in.n2}) begin
            shifted = shifted - {1'b0, cell_in.n2};
            stage_in.quo[k] = {cell_in.quo[k][q2m_pkg::QuoBits-2:0], 1'b1};
         end else begin
            stage_in.quo[k] = {cell_in.quo[k][q2m_pkg::QuoBits-2:0], 1'b0};
         end
         stage_in.rem[k] = shifted[q2m_pkg::NormWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.zero <= stage_in.zero;
      stage_ff.n2 <= stage_in.n2;
      stage_ff.neg <= stage_in.neg;
      stage_ff.rem <= stage_in.rem;
      stage_ff.quo <= stage_in.quo;
   end

   assign cell_out = stage_ff;
endmodule

@@ sv/q2m_front.sv @@
module q2m_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             valid,
   input  q2m_pkg::data_type x,
   input  q2m_pkg::data_type y,
   input  q2m_pkg::data_type z,
   input  q2m_pkg::data_type w,
   output q2m_pkg::div_type front_out
);
   localparam int PW = q2m_pkg::ProdWidth;
   localparam int NW = q2m_pkg::NumWidth;

   logic valid_ff;
   logic signed [PW-1:0] xx_ff, yy_ff, zz_ff, ww_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic signed [NW-1:0] num [q2m_pkg::NumElems];
   logic [q2m_pkg::NormWidth-1:0] n2;
   logic [NW-1:0] mag;
   q2m_pkg::div_type out_ff, out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid;
      end
      xx_ff <= x * x;
      yy_ff <= y * y;
      zz_ff <= z * z;
      ww_ff <= w * w;
      xy_ff <= x * y;
      xz_ff <= x * z;
      yz_ff <= y * z;
      wx_ff <= w * x;
      wy_ff <= w * y;
      wz_ff <= w * z;
   end

   always_comb begin
      n2 = q2m_pkg::NormWidth'(unsigned'(xx_ff)) + q2m_pkg::NormWidth'(unsigned'(yy_ff))
         + q2m_pkg::NormWidth'(unsigned'(zz_ff)) + q2m_pkg::NormWidth'(unsigned'(ww_ff));
      num[0] = NW'(ww_ff) + NW'(xx_ff) - NW'(yy_ff) - NW'(zz_ff);
      num[1] = (NW'(xy_ff) + NW'(wz_ff)) <<< 1;
      num[2] = (NW'(xz_ff) - NW'(wy_ff)) <<< 1;
      num[3] = (NW'(xy_ff) - NW'(wz_ff)) <<< 1;
      num[4] = NW'(ww_ff) + NW'(yy_ff) - NW'(xx_ff) - NW'(zz_ff);
      num[5] = (NW'(yz_ff) + NW'(wx_ff)) <<< 1;
      num[6] = (NW'(xz_ff) + NW'(wy_ff)) <<< 1;
      num[7] = (NW'(yz_ff) - NW'(wx_ff)) <<< 1;
      num[8] = NW'(ww_ff) + NW'(zz_ff) - NW'(xx_ff) - NW'(yy_ff);
      out_in.valid = valid_ff;
      out_in.zero = (n2 == '0);
      out_in.n2 = n2;
      mag = '0;
      for (int k = 0; k < q2m_pkg::NumElems; k++) begin
         out_in.neg[k] = num[k][NW-1];
         mag = num[k][NW-1] ? NW'(-num[k]) : NW'(num[k]);
         if (mag >= {1'b0, n2}) begin
            out_in.quo[k] = q2m_pkg::QuoBits'(1);
            out_in.rem[k] = '0;
         end else begin
            out_in.quo[k] = '0;
            out_in.rem[k] = mag[q2m_pkg::NormWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.zero <= out_in.zero;
      out_ff.n2 <= out_in.n2;
      out_ff.neg <= out_in.neg;
      out_ff.rem <= out_in.rem;
      out_ff.quo <= out_in.quo;
   end

   assign front_out = out_ff;
endmodule

@@ sv/quaternion_to_rotation_matrix.sv @@
// Quaternion (Q1.14, x y z w) to 3x3 rotation matrix (Q1.14 elements).
// Input: a transaction is accepted at a rising edge with start high and
// busy low. busy is always low, so a new quaternion may enter every cycle.
// Output: rsp_valid is high for exactly one cycle with m00..m22 and
// rsp_zero_norm; the receiver cannot stall and results are never held.
// Stages from acceptance to rsp_valid: one product stage, one numerator
// and norm stage, 15 restoring-division cells, one rounding stage.
// Throughput is one quaternion per cycle, set by the chain of
// division cells, each of which resolves one quotient bit of all nine
// elements and hands its partial remainders to the next cell.
// A zero norm yields the identity matrix with rsp_zero_norm set.
// Reset clears the valid bits of every stage; transactions in flight are
// dropped and no result appears until a new transaction passes through.
module quaternion_to_rotation_matrix (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  q2m_pkg::data_type req_quat_x,
   input  q2m_pkg::data_type req_quat_y,
   input  q2m_pkg::data_type req_quat_z,
   input  q2m_pkg::data_type req_quat_w,
   output logic             rsp_valid,
   output q2m_pkg::data_type rsp_m00,
   output q2m_pkg::data_type rsp_m01,
   output q2m_pkg::data_type rsp_m02,
   output q2m_pkg::data_type rsp_m10,
   output q2m_pkg::data_type rsp_m11,
   output q2m_pkg::data_type rsp_m12,
   output q2m_pkg::data_type rsp_m20,
   output q2m_pkg::data_type rsp_m21,
   output q2m_pkg::data_type rsp_m22,
   output logic             rsp_zero_norm
);
   localparam int DW = q2m_pkg::DataWidth;
   localparam int QB = q2m_pkg::QuoBits;
   localparam logic [QB-1:0] OneMag = QB'(1) << q2m_pkg::FracBits;

   q2m_pkg::div_type chain [q2m_pkg::NumCells+1];
   logic valid_ff;
   logic zero_ff;
   q2m_pkg::data_type elem_ff [q2m_pkg::NumElems];
   q2m_pkg::data_type elem_in [q2m_pkg::NumElems];
   logic [QB-1:0] mag;

   assign busy = 1'b0;

   q2m_front u_front (
      .clock     (clock),
      .reset     (reset),
      .valid     (start),
      .x         (req_quat_x),
      .y         (req_quat_y),
      .z         (req_quat_z),
      .w         (req_quat_w),
      .front_out (chain[0])
   );

   for (genvar i = 0; i < q2m_pkg::NumCells; i++) begin : g_cell
      q2m_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   always_comb begin
      mag = '0;
      for (int k = 0; k < q2m_pkg::NumElems; k++) begin
         mag = QB'((chain[q2m_pkg::NumCells].quo[k] + QB'(1)) >> 1);
         if (mag > OneMag) begin
            mag = OneMag;
         end
         if (chain[q2m_pkg::NumCells].zero) begin
            elem_in[k] = (k == 0 || k == 4 || k == 8) ? DW'(OneMag) : '0;
         end else if (chain[q2m_pkg::NumCells].neg[k]) begin
            elem_in[k] = DW'(-mag);
         end else begin
            elem_in[k] = DW'(mag);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= chain[q2m_pkg::NumCells].valid;
      end
      zero_ff <= chain[q2m_pkg::NumCells].zero;
      elem_ff <= elem_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_zero_norm = zero_ff;
   assign rsp_m00 = elem_ff[0];
   assign rsp_m01 = elem_ff[1];
   assign rsp_m02 = elem_ff[2];
   assign rsp_m10 = elem_ff[3];
   assign rsp_m11 = elem_ff[4];
   assign rsp_m12 = elem_ff[5];
   assign rsp_m20 = elem_ff[6];
   assign rsp_m21 = elem_ff[7];
   assign rsp_m22 = elem_ff[8];
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
   localparam int MaxCycles = 200000;
   localparam int Latency = 18;

   typedef struct {
      q2m_pkg::data_type x, y, z, w;
      logic hold;
   } quat_type;

   typedef struct {
      q2m_pkg::data_type m [9];
      logic zero_norm;
   } matrix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   q2m_pkg::data_type req_quat_x = '0, req_quat_y = '0, req_quat_z = '0, req_quat_w = '0;
   logic rsp_valid, rsp_zero_norm;
   q2m_pkg::data_type rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12;
   q2m_pkg::data_type rsp_m20, rsp_m21, rsp_m22;

   quat_type pending_quats[$];
   matrix_type expected_matrices[$];
   int errors = 0;
   int cycle_count = 0;
   int gap_left = 0;
   int burst_left = 0;
   bit stim_done = 0;
   bit waiting_drain = 0;

   quaternion_to_rotation_matrix dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic q2m_pkg::data_type ratio_to_fix(longint num, longint n2);
      longint a, q, r, mag;
      bit neg;
      neg = num < 0;
      a = neg ? -num : num;
      if (a > n2) a = n2;
      q = a / n2;
      r = a % n2;
      for (int i = 0; i < q2m_pkg::FracBits + 1; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= n2) begin
            r -= n2;
            q |= 1;
         end
      end
      mag = (q + 1) >>> 1;
      if (mag > (64'sd1 <<< q2m_pkg::FracBits)) mag = 64'sd1 <<< q2m_pkg::FracBits;
      return q2m_pkg::data_type'(neg ? -mag : mag);
   endfunction

   function automatic matrix_type rotation_of(quat_type q);
      matrix_type res;
      longint x, y, z, w, xx, yy, zz, ww, n2;
      x = q.x; y = q.y; z = q.z; w = q.w;
      xx = x * x; yy = y * y; zz = z * z; ww = w * w;
      n2 = xx + yy + zz + ww;
      if (n2 == 0) begin
         foreach (res.m[k]) res.m[k] = '0;
         res.m[0] = q2m_pkg::data_type'(1 << q2m_pkg::FracBits);
         res.m[4] = q2m_pkg::data_type'(1 << q2m_pkg::FracBits);
         res.m[8] = q2m_pkg::data_type'(1 << q2m_pkg::FracBits);
         res.zero_norm = 1'b1;
         return res;
      end
      res.m[0] = ratio_to_fix(ww + xx - yy - zz, n2);
      res.m[1] = ratio_to_fix(2 * (x * y + w * z), n2);
      res.m[2] = ratio_to_fix(2 * (x * z - w * y), n2);
      res.m[3] = ratio_to_fix(2 * (x * y - w * z), n2);
      res.m[4] = ratio_to_fix(ww + yy - xx - zz, n2);
      res.m[5] = ratio_to_fix(2 * (y * z + w * x), n2);
      res.m[6] = ratio_to_fix(2 * (x * z + w * y), n2);
      res.m[7] = ratio_to_fix(2 * (y * z - w * x), n2);
      res.m[8] = ratio_to_fix(ww + zz - xx - yy, n2);
      res.zero_norm = 1'b0;
      return res;
   endfunction

   task automatic push_quat(int x, int y, int z, int w, bit hold = 0);
      quat_type q;
      q.x = q2m_pkg::data_type'(x); q.y = q2m_pkg::data_type'(y);
      q.z = q2m_pkg::data_type'(z); q.w = q2m_pkg::data_type'(w);
      q.hold = hold;
      pending_quats.push_back(q);
   endtask

   function automatic int rand_comp(int mode);
      case (mode)
         0: return $urandom_range(0, 65535) - 32768;
         1: return $urandom_range(0, 32768) - 16384;
         2: return $urandom_range(0, 8) - 4;
         default: return 0;
      endcase
   endfunction

   initial begin
      int m;
      push_quat(0, 0, 0, 0);
      push_quat(0, 0, 0, 16384);
      push_quat(16384, 0, 0, 0);
      push_quat(0, 16384, 0, 0);
      push_quat(0, 0, 16384, 0);
      push_quat(-32768, -32768, -32768, -32768);
      push_quat(32767, 32767, 32767, 32767);
      push_quat(-32768, 0, 0, 0);
      push_quat(0, 0, 0, -32768);
      push_quat(32767, -32768, 32767, -32768);
      push_quat(1, 0, 0, 0);
      push_quat(0, 0, 0, -1);
      push_quat(1, 1, 1, 1);
      push_quat(8192, 8192, 8192, 8192, 1);
      push_quat(11585, 0, 0, 11585);
      push_quat(-1, -1, 0, 0);
      push_quat(32767, 1, -1, 0);
      push_quat(0, 0, 0, 0);
      for (int i = 0; i < 600; i++) begin
         m = $urandom_range(0, 9);
         if (m < 5) m = 0; else if (m < 8) m = 1; else if (m < 9) m = 2; else m = 3;
         push_quat(rand_comp(m), rand_comp(m), rand_comp(m), rand_comp(m), i == 300);
      end
   end

   always @(negedge clock) begin
      if (reset || waiting_drain) begin
         start <= 1'b0;
         if (waiting_drain && expected_matrices.size() == 0 && !rsp_valid)
            waiting_drain <= 1'b0;
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_quats.size() == 0) begin
         start <= 1'b0;
         stim_done <= 1'b1;
      end else begin
         quat_type q;
         q = pending_quats.pop_front();
         start <= 1'b1;
         req_quat_x <= q.x; req_quat_y <= q.y;
         req_quat_z <= q.z; req_quat_w <= q.w;
         if (q.hold) begin
            waiting_drain <= 1'b1;
         end else if (burst_left > 0) begin
            burst_left <= burst_left - 1;
         end else begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && start && !busy)
         expected_matrices.push_back(rotation_of(quat_type'{req_quat_x, req_quat_y,
                                                            req_quat_z, req_quat_w,
                                                            1'b0}));
      if (!reset && rsp_valid) begin
         q2m_pkg::data_type got [9];
         matrix_type exp_m;
         got = '{rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12,
                 rsp_m20, rsp_m21, rsp_m22};
         if (expected_matrices.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
         end else begin
            exp_m = expected_matrices.pop_front();
            for (int k = 0; k < 9; k++)
               if (got[k] !== exp_m.m[k]) begin
                  $error("m%0d%0d expected %0d actual %0d", k / 3, k % 3,
                         exp_m.m[k], got[k]);
                  errors++;
               end
            if (rsp_zero_norm !== exp_m.zero_norm) begin
               $error("zero_norm expected %0b actual %0b", exp_m.zero_norm,
                      rsp_zero_norm);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      fork
         begin
            wait (stim_done && expected_matrices.size() == 0);
            repeat (Latency + 10) @(posedge clock);
         end
         begin
            wait (cycle_count >= MaxCycles);
            $display("*** FAILED ***");
            $finish;
         end
      join_any
      if (errors == 0 && expected_matrices.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

@@ filelist.f @@
sv/q2m_pkg.sv
sv/q2m_cell.sv
sv/q2m_front.sv
sv/quaternion_to_rotation_matrix.sv
bench/tb.sv
